// ===== sv/trcp_pkg.sv =====
// shared constants, types and saturating helpers for the two-ray closest-point block
package trcp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;
    localparam int MIN_DET_W = 31;
    localparam int MUL_LAT   = 5;
    localparam int NUM_W     = 64 + FRAC_BITS;
    localparam int DIV_STEPS = NUM_W;

    // register stages, counted from the input register
    localparam int ST_DOT   = MUL_LAT + 1;
    localparam int ST_DET   = ST_DOT + MUL_LAT + 1;
    localparam int ST_DPREP = ST_DET + 1;
    localparam int ST_TS    = ST_DPREP + DIV_STEPS + 1;
    localparam int ST_P     = ST_TS + MUL_LAT + 1;
    localparam int ST_MID   = ST_P + 1;
    localparam int ST_OUT   = ST_MID + MUL_LAT + 1;
    localparam int LATENCY  = ST_OUT + 1;

    localparam logic [MIN_DET_W-1:0] MIN_DET_RST = MIN_DET_W'(655);
    localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};
    localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef struct packed {
        logic [2:0][COORD_W-1:0] da;
        logic [2:0][COORD_W-1:0] oa;
        logic [2:0][COORD_W-1:0] db;
        logic [2:0][COORD_W-1:0] ob;
    } t_geo;

    typedef struct packed {
        logic [63:0]      rem;
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] quo;
    } t_dv;

    function automatic logic signed [63:0] sat65(input logic signed [64:0] v);
        logic signed [63:0] r;
        if (v[64] != v[63]) begin
            r = v[64] ? S64_MIN : S64_MAX;
        end else begin
            r = v[63:0];
        end
        return r;
    endfunction

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
        return sat65({a[63], a} + {b[63], b});
    endfunction

    function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
        return sat65({a[63], a} - {b[63], b});
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

endpackage

// ===== sv/trcp_mul.sv =====
// pipelined 64 x 64 signed multiplier with optional rounded fraction shift and saturation
module trcp_mul (
    input  logic               i_clk,
    input  logic signed [63:0] i_x,
    input  logic signed [63:0] i_y,
    input  logic               i_shift,
    output logic signed [63:0] o_p
);
    import trcp_pkg::*;

    logic [63:0]        r_mx, r_my;
    logic               r_neg1, r_sh1;
    logic [63:0]        r_p00, r_p01, r_p10, r_p11;
    logic               r_neg2, r_sh2;
    logic [127:0]       r_full;
    logic               r_neg3, r_sh3;
    logic [127:0]       r_mag;
    logic               r_neg4;
    logic signed [63:0] r_p;
    logic [127:0]       n_mag;
    logic signed [63:0] n_p;

    always_comb begin
        if (r_sh3) begin
            n_mag = (r_full + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        end else begin
            n_mag = r_full;
        end
    end

    always_comb begin
        if (|r_mag[127:63]) begin
            n_p = r_neg4 ? S64_MIN : S64_MAX;
        end else if (r_neg4) begin
            n_p = -$signed({1'b0, r_mag[62:0]});
        end else begin
            n_p = $signed({1'b0, r_mag[62:0]});
        end
    end

    always_ff @(posedge i_clk) begin
        r_mx   <= mag64(i_x);
        r_my   <= mag64(i_y);
        r_neg1 <= i_x[63] ^ i_y[63];
        r_sh1  <= i_shift;
        r_p00  <= r_mx[31:0] * r_my[31:0];
        r_p01  <= r_mx[31:0] * r_my[63:32];
        r_p10  <= r_mx[63:32] * r_my[31:0];
        r_p11  <= r_mx[63:32] * r_my[63:32];
        r_neg2 <= r_neg1;
        r_sh2  <= r_sh1;
        r_full <= {r_p11, 64'd0} + {32'd0, r_p01, 32'd0} + {32'd0, r_p10, 32'd0}
                  + {64'd0, r_p00};
        r_neg3 <= r_neg2;
        r_sh3  <= r_sh2;
        r_mag  <= n_mag;
        r_neg4 <= r_neg3;
        r_p    <= n_p;
    end

    assign o_p = r_p;

endmodule

// ===== sv/two_ray_closest_point.sv =====
// two-ray closest-point triangulation: midpoint, signed squared gap and solve flag
// the result strobe follows the start cycle through every register stage (LATENCY in trcp_pkg)
// throughput: one word per cycle, busy is never raised
// the depth is set by the 80 one-bit stages of the pipelined divider and four multiplier ranks
// results cannot be stalled by the receiver
// reset clears the valid pipeline and loads min_determinant with 655
module two_ray_closest_point (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    output logic                                  o_busy,
    input  logic                                  i_cfg_we,
    input  logic [trcp_pkg::MIN_DET_W-1:0]        i_cfg_wdata,
    input  logic signed [trcp_pkg::COORD_W-1:0]   i_dir_a_x,
    input  logic signed [trcp_pkg::COORD_W-1:0]   i_dir_a_y,
    input  logic signed [trcp_pkg::COORD_W-1:0]   i_dir_a_z,
    input  logic signed [trcp_pkg::COORD_W-1:0]   i_origin_a_x,
    input  logic signed [trcp_pkg::COORD_W-1:0]   i_origin_a_y,
    input  logic signed [trcp_pkg::COORD_W-1:0]   i_origin_a_z,
    input  logic signed [trcp_pkg::COORD_W-1:0]   i_dir_b_x,
    input  logic signed [trcp_pkg::COORD_W-1:0]   i_dir_b_y,
    input  logic signed [trcp_pkg::COORD_W-1:0]   i_dir_b_z,
    input  logic signed [trcp_pkg::COORD_W-1:0]   i_origin_b_x,
    input  logic signed [trcp_pkg::COORD_W-1:0]   i_origin_b_y,
    input  logic signed [trcp_pkg::COORD_W-1:0]   i_origin_b_z,
    output logic                                  o_done,
    output logic signed [trcp_pkg::COORD_W-1:0]   o_mid_x,
    output logic signed [trcp_pkg::COORD_W-1:0]   o_mid_y,
    output logic signed [trcp_pkg::COORD_W-1:0]   o_mid_z,
    output logic signed [63:0]                    o_gap_error,
    output logic                                  o_valid_res
);
    import trcp_pkg::*;

    logic [MIN_DET_W-1:0]      r_min_det;
    logic                      r_vld [0:ST_OUT];
    t_geo                      r_geo [0:ST_TS+MUL_LAT];
    logic [2:0][COORD_W:0]     r_w;
    logic signed [63:0]        r_a, r_b, r_c, r_d1, r_d2;
    logic signed [63:0]        r_det, r_nt, r_ns;
    logic                      r_ok [ST_DET:ST_OUT-1];
    t_dv                       r_dv_t [0:DIV_STEPS];
    t_dv                       r_dv_s [0:DIV_STEPS];
    logic [63:0]               r_dd [0:DIV_STEPS];
    logic                      r_neg_t [0:DIV_STEPS];
    logic                      r_neg_s [0:DIV_STEPS];
    logic signed [63:0]        r_t, r_s;
    logic                      r_bhd [ST_TS:ST_OUT-1];
    logic signed [63:0]        r_p1 [3];
    logic signed [63:0]        r_p2 [3];
    logic signed [63:0]        r_diff [3];
    logic [2:0][COORD_W-1:0]   r_mid [ST_MID:ST_OUT-1];
    logic [2:0][COORD_W-1:0]   r_out_mid;
    logic signed [63:0]        r_out_gap;
    logic                      r_out_ok;

    logic signed [63:0] m_aa [3];
    logic signed [63:0] m_ab [3];
    logic signed [63:0] m_bb [3];
    logic signed [63:0] m_wa [3];
    logic signed [63:0] m_wb [3];
    logic signed [63:0] m_b2, m_ac, m_d2b, m_d1c, m_d2a, m_d1b;
    logic signed [63:0] m_td [3];
    logic signed [63:0] m_sd [3];
    logic signed [63:0] m_sq [3];
    logic signed [63:0] n_det, n_t, n_s;
    logic [2:0][COORD_W-1:0] n_mid;
    logic [65:0]        n_gsum;
    logic signed [63:0] n_gap;

    function automatic t_dv dv_step(input t_dv s, input logic [63:0] d);
        t_dv         r;
        logic [64:0] rem2;
        logic        ge;
        rem2  = {s.rem, s.num[NUM_W-1]};
        ge    = rem2 >= {1'b0, d};
        r.rem = ge ? 64'(rem2 - {1'b0, d}) : rem2[63:0];
        r.num = {s.num[NUM_W-2:0], 1'b0};
        r.quo = {s.quo[NUM_W-2:0], ge};
        return r;
    endfunction

    function automatic logic signed [63:0] dv_fin(input t_dv s, input logic neg);
        logic signed [63:0] r;
        if (|s.quo[NUM_W-1:63]) begin
            r = neg ? S64_MIN : S64_MAX;
        end else if (neg) begin
            r = -$signed({1'b0, s.quo[62:0]});
        end else begin
            r = $signed({1'b0, s.quo[62:0]});
        end
        return r;
    endfunction

    function automatic logic [COORD_W-1:0] mid_of(input logic signed [63:0] p1,
                                                   input logic signed [63:0] p2);
        logic signed [64:0] sum;
        logic signed [64:0] h;
        logic [COORD_W-1:0] r;
        sum = {p1[63], p1} + {p2[63], p2};
        h   = sum >>> 1;
        if (h > 65'(C_MAX)) begin
            r = C_MAX;
        end else if (h < 65'(C_MIN)) begin
            r = C_MIN;
        end else begin
            r = h[COORD_W-1:0];
        end
        return r;
    endfunction

    assign o_busy = 1'b0;

    // multiplier rank for the dot products
    for (genvar k = 0; k < 3; k++) begin : g_dot
        trcp_mul u_aa (.i_clk(i_clk), .i_x(64'($signed(r_geo[0].da[k]))),
                       .i_y(64'($signed(r_geo[0].da[k]))), .i_shift(1'b1), .o_p(m_aa[k]));
        trcp_mul u_ab (.i_clk(i_clk), .i_x(64'($signed(r_geo[0].da[k]))),
                       .i_y(64'($signed(r_geo[0].db[k]))), .i_shift(1'b1), .o_p(m_ab[k]));
        trcp_mul u_bb (.i_clk(i_clk), .i_x(64'($signed(r_geo[0].db[k]))),
                       .i_y(64'($signed(r_geo[0].db[k]))), .i_shift(1'b1), .o_p(m_bb[k]));
        trcp_mul u_wa (.i_clk(i_clk), .i_x(64'($signed(r_w[k]))),
                       .i_y(64'($signed(r_geo[0].da[k]))), .i_shift(1'b1), .o_p(m_wa[k]));
        trcp_mul u_wb (.i_clk(i_clk), .i_x(64'($signed(r_w[k]))),
                       .i_y(64'($signed(r_geo[0].db[k]))), .i_shift(1'b1), .o_p(m_wb[k]));
    end

    // determinant and numerators
    trcp_mul u_b2  (.i_clk(i_clk), .i_x(r_b),  .i_y(r_b), .i_shift(1'b1), .o_p(m_b2));
    trcp_mul u_ac  (.i_clk(i_clk), .i_x(r_a),  .i_y(r_c), .i_shift(1'b1), .o_p(m_ac));
    trcp_mul u_d2b (.i_clk(i_clk), .i_x(r_d2), .i_y(r_b), .i_shift(1'b1), .o_p(m_d2b));
    trcp_mul u_d1c (.i_clk(i_clk), .i_x(r_d1), .i_y(r_c), .i_shift(1'b1), .o_p(m_d1c));
    trcp_mul u_d2a (.i_clk(i_clk), .i_x(r_d2), .i_y(r_a), .i_shift(1'b1), .o_p(m_d2a));
    trcp_mul u_d1b (.i_clk(i_clk), .i_x(r_d1), .i_y(r_b), .i_shift(1'b1), .o_p(m_d1b));

    // closest points and squared gap
    for (genvar k = 0; k < 3; k++) begin : g_pt
        trcp_mul u_td (.i_clk(i_clk), .i_x(r_t), .i_y(64'($signed(r_geo[ST_TS].da[k]))),
                       .i_shift(1'b1), .o_p(m_td[k]));
        trcp_mul u_sd (.i_clk(i_clk), .i_x(r_s), .i_y(64'($signed(r_geo[ST_TS].db[k]))),
                       .i_shift(1'b1), .o_p(m_sd[k]));
        trcp_mul u_sq (.i_clk(i_clk), .i_x(r_diff[k]), .i_y(r_diff[k]),
                       .i_shift(1'b0), .o_p(m_sq[k]));
    end

    assign n_det = sat_sub(m_b2, m_ac);
    assign n_t   = dv_fin(r_dv_t[DIV_STEPS], r_neg_t[DIV_STEPS]);
    assign n_s   = dv_fin(r_dv_s[DIV_STEPS], r_neg_s[DIV_STEPS]);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_mid[k] = mid_of(r_p1[k], r_p2[k]);
        end
    end

    always_comb begin
        n_gsum = {2'b00, m_sq[0]} + {2'b00, m_sq[1]} + {2'b00, m_sq[2]};
        if (n_gsum > 66'(S64_MAX)) begin
            n_gap = S64_MAX;
        end else begin
            n_gap = n_gsum[63:0];
        end
        if (r_bhd[ST_OUT-1]) begin
            n_gap = -n_gap;
        end
    end

    // control: config register and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_det <= MIN_DET_RST;
            for (int i = 0; i <= ST_OUT; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else begin
            if (i_cfg_we) begin
                r_min_det <= i_cfg_wdata;
            end
            r_vld[0] <= i_start;
            for (int i = 1; i <= ST_OUT; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_geo[0].da <= {i_dir_a_z, i_dir_a_y, i_dir_a_x};
        r_geo[0].oa <= {i_origin_a_z, i_origin_a_y, i_origin_a_x};
        r_geo[0].db <= {i_dir_b_z, i_dir_b_y, i_dir_b_x};
        r_geo[0].ob <= {i_origin_b_z, i_origin_b_y, i_origin_b_x};
        r_w[0] <= (COORD_W+1)'(i_origin_b_x) - (COORD_W+1)'(i_origin_a_x);
        r_w[1] <= (COORD_W+1)'(i_origin_b_y) - (COORD_W+1)'(i_origin_a_y);
        r_w[2] <= (COORD_W+1)'(i_origin_b_z) - (COORD_W+1)'(i_origin_a_z);
        for (int i = 1; i <= ST_TS + MUL_LAT; i++) begin
            r_geo[i] <= r_geo[i-1];
        end

        r_a  <= m_aa[0] + m_aa[1] + m_aa[2];
        r_b  <= m_ab[0] + m_ab[1] + m_ab[2];
        r_c  <= m_bb[0] + m_bb[1] + m_bb[2];
        r_d1 <= m_wa[0] + m_wa[1] + m_wa[2];
        r_d2 <= m_wb[0] + m_wb[1] + m_wb[2];

        r_det       <= n_det;
        r_nt        <= sat_sub(m_d2b, m_d1c);
        r_ns        <= sat_sub(m_d2a, m_d1b);
        r_ok[ST_DET] <= mag64(n_det) > 64'(r_min_det);
        for (int i = ST_DET + 1; i <= ST_OUT - 1; i++) begin
            r_ok[i] <= r_ok[i-1];
        end

        // divider: one quotient bit per stage for t and s
        r_dv_t[0]  <= '{rem: 64'd0, num: {mag64(r_nt), {FRAC_BITS{1'b0}}}, quo: '0};
        r_dv_s[0]  <= '{rem: 64'd0, num: {mag64(r_ns), {FRAC_BITS{1'b0}}}, quo: '0};
        r_dd[0]    <= mag64(r_det);
        r_neg_t[0] <= r_nt[63] ^ r_det[63];
        r_neg_s[0] <= r_ns[63] ^ r_det[63];
        for (int j = 0; j < DIV_STEPS; j++) begin
            r_dv_t[j+1]  <= dv_step(r_dv_t[j], r_dd[j]);
            r_dv_s[j+1]  <= dv_step(r_dv_s[j], r_dd[j]);
            r_dd[j+1]    <= r_dd[j];
            r_neg_t[j+1] <= r_neg_t[j];
            r_neg_s[j+1] <= r_neg_s[j];
        end

        r_t         <= n_t;
        r_s         <= n_s;
        r_bhd[ST_TS] <= n_t[63] | n_s[63];
        for (int i = ST_TS + 1; i <= ST_OUT - 1; i++) begin
            r_bhd[i] <= r_bhd[i-1];
        end

        for (int k = 0; k < 3; k++) begin
            r_p1[k]   <= sat_add(64'($signed(r_geo[ST_TS+MUL_LAT].oa[k])), m_td[k]);
            r_p2[k]   <= sat_add(64'($signed(r_geo[ST_TS+MUL_LAT].ob[k])), m_sd[k]);
            r_diff[k] <= sat_sub(r_p1[k], r_p2[k]);
        end
        r_mid[ST_MID] <= n_mid;
        for (int i = ST_MID + 1; i <= ST_OUT - 1; i++) begin
            r_mid[i] <= r_mid[i-1];
        end

        // near-parallel rays give an all-zero word
        r_out_ok  <= r_ok[ST_OUT-1];
        r_out_mid <= r_ok[ST_OUT-1] ? r_mid[ST_OUT-1] : '0;
        r_out_gap <= r_ok[ST_OUT-1] ? n_gap : 64'sd0;
    end

    assign o_done      = r_vld[ST_OUT];
    assign o_mid_x     = r_out_mid[0];
    assign o_mid_y     = r_out_mid[1];
    assign o_mid_z     = r_out_mid[2];
    assign o_gap_error = r_out_gap;
    assign o_valid_res = r_out_ok;

`ifndef SYNTH
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##LATENCY o_done)
        else $error("word not delivered after pipeline latency");

    a_zero_when_parallel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_valid_res) |->
            (o_gap_error == 64'sd0 && o_mid_x == '0 && o_mid_y == '0 && o_mid_z == '0))
        else $error("unsolved word carries non-zero fields");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("strobe raised straight after reset");
`endif

endmodule
